@@ src/smpc_pkg.sv @@
// Shared types and constants for the soil moisture pump controller.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package smpc_pkg;

    localparam int SAMPLE_W        = 10;
    localparam int PCT_W           = 7;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 10;
    localparam int WINDOW_DEFAULT  = 5;

    localparam int ANOMALY_LIMIT   = 300;
    localparam int FULL_SCALE      = 1023;
    localparam int PERCENT_SCALE   = 100;
    localparam int THRESHOLD_RESET = 500;

    // mean * 100 / 1023 as a multiply by a rounded-up reciprocal and a shift
    localparam int PCT_SHIFT       = 21;
    localparam int PCT_MULT_W      = 18;
    localparam logic [PCT_MULT_W-1:0] PCT_MULT =
        PCT_MULT_W'((PERCENT_SCALE * (1 << PCT_SHIFT) + FULL_SCALE - 1) / FULL_SCALE);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IDX_THRESHOLD = 1'b0;
    localparam t_cfg_idx CFG_IDX_MODE      = 1'b1;

    typedef enum logic [1:0] {
        MODE_AUTO      = 2'd0,
        MODE_FORCE_ON  = 2'd1,
        MODE_FORCE_OFF = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        LAMP_RED    = 2'd0,
        LAMP_YELLOW = 2'd1,
        LAMP_GREEN  = 2'd2
    } t_lamp;

    typedef struct packed {
        logic [SAMPLE_W-1:0] dry_threshold;
        t_mode               work_mode;
    } t_cfg;

endpackage

@@ src/smpc_if.sv @@
// Valid/ready channel interfaces for the sample word and the result word.
// Depends on smpc_pkg for field widths.
`timescale 1ns / 1ps

interface smpc_in_if;
    logic                          valid;
    logic                          ready;
    logic [smpc_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface smpc_out_if;
    logic                          valid;
    logic                          ready;
    logic [smpc_pkg::SAMPLE_W-1:0] mean_level;
    logic                          anomaly;
    logic [smpc_pkg::PCT_W-1:0]    dry_percent;
    logic                          pump_on;
    logic [1:0]                    lamp_select;

    modport source (output valid, output mean_level, output anomaly, output dry_percent,
                    output pump_on, output lamp_select, input ready);
    modport sink   (input valid, input mean_level, input anomaly, input dry_percent,
                    input pump_on, input lamp_select, output ready);
endinterface

@@ src/smpc_cell.sv @@
// One tap of the sample window: holds a sample and on a shift takes i_prev, or i_fill_data while i_fill is set.
// Depends on smpc_pkg for the sample width.
`timescale 1ns / 1ps

module smpc_cell (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic                          i_fill,
    input  logic [smpc_pkg::SAMPLE_W-1:0] i_fill_data,
    input  logic [smpc_pkg::SAMPLE_W-1:0] i_prev,
    output logic [smpc_pkg::SAMPLE_W-1:0] o_data
);

    logic [smpc_pkg::SAMPLE_W-1:0] r_data;
    logic [smpc_pkg::SAMPLE_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_shift) begin
            n_data = i_fill ? i_fill_data : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ src/smpc_window.sv @@
// Sample window: chain of smpc_cell taps plus the running sum, first pipeline stage.
// Depends on smpc_pkg and smpc_cell.
`timescale 1ns / 1ps

module smpc_window #(
    parameter int WINDOW = smpc_pkg::WINDOW_DEFAULT,
    localparam int SUM_W = smpc_pkg::SAMPLE_W + $clog2(WINDOW)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [smpc_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_ready,
    input  logic                          i_s2_ready,
    output logic                          o_s1_valid,
    output logic [smpc_pkg::SAMPLE_W-1:0] o_s1_sample,
    output logic [SUM_W-1:0]              o_s1_sum
);

    logic                          w_accept;
    logic [smpc_pkg::SAMPLE_W-1:0] w_tap [WINDOW];
    logic [SUM_W-1:0]              w_fill_sum;
    logic [SUM_W:0]                w_run_sum;

    logic                          r_primed;
    logic                          n_primed;
    logic                          r_s1_v;
    logic                          n_s1_v;
    logic [smpc_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic [SUM_W-1:0]              r_sum;
    logic [SUM_W-1:0]              n_sum;

    assign o_ready  = !r_s1_v || i_s2_ready;
    assign w_accept = i_valid && o_ready;

    for (genvar k = 0; k < WINDOW; k++) begin : g_tap
        if (k == 0) begin : g_head
            smpc_cell u_cell (
                .i_clk       (i_clk),
                .i_shift     (w_accept),
                .i_fill      (!r_primed),
                .i_fill_data (i_sample),
                .i_prev      (i_sample),
                .o_data      (w_tap[k])
            );
        end else begin : g_body
            smpc_cell u_cell (
                .i_clk       (i_clk),
                .i_shift     (w_accept),
                .i_fill      (!r_primed),
                .i_fill_data (i_sample),
                .i_prev      (w_tap[k-1]),
                .o_data      (w_tap[k])
            );
        end
    end

    assign w_fill_sum = SUM_W'(i_sample) * SUM_W'(WINDOW);
    assign w_run_sum  = {1'b0, r_sum} + (SUM_W+1)'(i_sample) - (SUM_W+1)'(w_tap[WINDOW-1]);

    always_comb begin
        n_primed = r_primed || w_accept;
        n_sum    = r_sum;
        if (w_accept) begin
            n_sum = r_primed ? w_run_sum[SUM_W-1:0] : w_fill_sum;
        end
        n_s1_v = r_s1_v;
        if (w_accept) begin
            n_s1_v = 1'b1;
        end else if (i_s2_ready) begin
            n_s1_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_s1_v   <= 1'b0;
        end else begin
            r_primed <= n_primed;
            r_s1_v   <= n_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        if (w_accept) begin
            r_s1_sample <= i_sample;
        end
    end

    assign o_s1_valid  = r_s1_v;
    assign o_s1_sample = r_s1_sample;
    assign o_s1_sum    = r_sum;

    a_valid_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> r_primed)
        else $error("stage one holds a word before the window is primed");

    a_fill_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_primed) |=> (r_sum == SUM_W'($past(i_sample)) * SUM_W'(WINDOW)))
        else $error("first word did not fill the running sum");

endmodule

@@ src/smpc_eval.sv @@
// Mean, dryness percent, anomaly check and pump/lamp decision; stages two and three.
// Depends on smpc_pkg and smpc_if.
`timescale 1ns / 1ps

module smpc_eval #(
    parameter int WINDOW = smpc_pkg::WINDOW_DEFAULT,
    localparam int SUM_W = smpc_pkg::SAMPLE_W + $clog2(WINDOW)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s1_valid,
    input  logic [smpc_pkg::SAMPLE_W-1:0] i_s1_sample,
    input  logic [SUM_W-1:0]              i_s1_sum,
    output logic                          o_s2_ready,
    input  smpc_pkg::t_cfg                i_cfg,
    smpc_out_if.source                    o_out
);

    localparam int MEAN_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int MULT_W     = SUM_W + 1;
    localparam int PROD_W     = SUM_W + MULT_W;
    localparam int PCT_PROD_W = smpc_pkg::SAMPLE_W + smpc_pkg::PCT_MULT_W;
    localparam logic [MULT_W-1:0] MEAN_MULT =
        MULT_W'(((1 << MEAN_SHIFT) + WINDOW - 1) / WINDOW);

    logic                          w_out_ready;
    logic                          w_s2_load;
    logic                          w_out_load;
    logic [PROD_W-1:0]             w_mean_prod;
    logic [PCT_PROD_W-1:0]         w_pct_prod;
    logic [smpc_pkg::SAMPLE_W-1:0] w_diff;
    logic                          w_anom;
    logic                          w_pump;
    smpc_pkg::t_lamp               w_lamp;

    logic                          r_s2_v;
    logic                          n_s2_v;
    logic [smpc_pkg::SAMPLE_W-1:0] r_s2_sample;
    logic [smpc_pkg::SAMPLE_W-1:0] r_s2_mean;
    logic                          r_out_v;
    logic                          n_out_v;
    logic [smpc_pkg::SAMPLE_W-1:0] r_mean;
    logic                          r_anom;
    logic [smpc_pkg::PCT_W-1:0]    r_pct;
    logic                          r_pump;
    smpc_pkg::t_lamp               r_lamp;

    assign w_out_ready = !r_out_v || o_out.ready;
    assign o_s2_ready  = !r_s2_v || w_out_ready;
    assign w_s2_load   = i_s1_valid && o_s2_ready;
    assign w_out_load  = r_s2_v && w_out_ready;

    assign w_mean_prod = PROD_W'(i_s1_sum) * PROD_W'(MEAN_MULT);
    assign w_pct_prod  = PCT_PROD_W'(r_s2_mean) * PCT_PROD_W'(smpc_pkg::PCT_MULT);
    assign w_diff      = (r_s2_sample >= r_s2_mean) ? (r_s2_sample - r_s2_mean)
                                                    : (r_s2_mean - r_s2_sample);
    assign w_anom      = w_diff > smpc_pkg::SAMPLE_W'(smpc_pkg::ANOMALY_LIMIT);

    always_comb begin
        w_pump = 1'b0;
        w_lamp = smpc_pkg::LAMP_RED;
        if (w_anom) begin
            w_lamp = smpc_pkg::LAMP_YELLOW;
        end else begin
            unique case (i_cfg.work_mode)
                smpc_pkg::MODE_FORCE_ON: begin
                    w_pump = 1'b1;
                    w_lamp = smpc_pkg::LAMP_GREEN;
                end
                smpc_pkg::MODE_FORCE_OFF: begin
                    w_pump = 1'b0;
                    w_lamp = smpc_pkg::LAMP_RED;
                end
                default: begin
                    if (r_s2_mean > i_cfg.dry_threshold) begin
                        w_pump = 1'b1;
                        w_lamp = smpc_pkg::LAMP_GREEN;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_s2_v = r_s2_v;
        if (w_s2_load) begin
            n_s2_v = 1'b1;
        end else if (w_out_ready) begin
            n_s2_v = 1'b0;
        end
        n_out_v = r_out_v;
        if (w_out_load) begin
            n_out_v = 1'b1;
        end else if (o_out.ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s2_v  <= n_s2_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_s2_sample <= i_s1_sample;
            r_s2_mean   <= w_mean_prod[MEAN_SHIFT +: smpc_pkg::SAMPLE_W];
        end
        if (w_out_load) begin
            r_mean <= r_s2_mean;
            r_anom <= w_anom;
            r_pct  <= w_pct_prod[smpc_pkg::PCT_SHIFT +: smpc_pkg::PCT_W];
            r_pump <= w_pump;
            r_lamp <= w_lamp;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.mean_level  = r_mean;
    assign o_out.anomaly     = r_anom;
    assign o_out.dry_percent = r_pct;
    assign o_out.pump_on     = r_pump;
    assign o_out.lamp_select = r_lamp;

    a_anom_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_anom) |-> (!r_pump && r_lamp == smpc_pkg::LAMP_YELLOW))
        else $error("anomaly word does not stop the pump");

    a_pump_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_pump) |-> (r_lamp == smpc_pkg::LAMP_GREEN && !r_anom))
        else $error("pump on without the green lamp");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_pct <= smpc_pkg::PCT_W'(smpc_pkg::PERCENT_SCALE)))
        else $error("dryness percent above full scale");

endmodule

@@ src/soil_moisture_pump_control_top.sv @@
// Soil moisture pump controller, top level: configuration registers and stage wiring.
// Depends on smpc_pkg, smpc_if, smpc_window and smpc_eval.
`timescale 1ns / 1ps

// Usage:
//   i_in carries one 10-bit moisture sample per word (valid/ready). o_out carries one
//   result word per sample: mean of the last WINDOW samples, anomaly flag, dryness
//   percent, pump command and lamp code.
//   Configuration: i_cfg_we with i_cfg_idx 0 writes the dry threshold, index 1 the
//   work mode; write only while no word is in flight.
//   Throughput: one word per cycle while o_out.ready stays high. A sample passes the
//   window/sum register, the mean multiply register and the result register before
//   o_out can pass its result on.
//   Each stage holds its word while the next one is full, so a stalled o_out.ready
//   still lets i_in fill empty stages before i_in.ready drops.
//   Reset: synchronous, active low; pipeline empty, threshold 500, mode auto, window
//   unprimed. The first sample after reset fills every window tap.

module soil_moisture_pump_control_top #(
    parameter int WINDOW = smpc_pkg::WINDOW_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    smpc_in_if.sink                         i_in,
    smpc_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [smpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [smpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W = smpc_pkg::SAMPLE_W + $clog2(WINDOW);

    smpc_pkg::t_cfg                r_cfg;
    smpc_pkg::t_cfg                n_cfg;
    logic                          w_s2_ready;
    logic                          w_s1_valid;
    logic [smpc_pkg::SAMPLE_W-1:0] w_s1_sample;
    logic [SUM_W-1:0]              w_s1_sum;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smpc_pkg::CFG_IDX_THRESHOLD:
                    n_cfg.dry_threshold = i_cfg_data[smpc_pkg::SAMPLE_W-1:0];
                smpc_pkg::CFG_IDX_MODE:
                    n_cfg.work_mode = smpc_pkg::t_mode'(i_cfg_data[1:0]);
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dry_threshold <= smpc_pkg::SAMPLE_W'(smpc_pkg::THRESHOLD_RESET);
            r_cfg.work_mode     <= smpc_pkg::MODE_AUTO;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    smpc_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_sample    (i_in.sample),
        .o_ready     (i_in.ready),
        .i_s2_ready  (w_s2_ready),
        .o_s1_valid  (w_s1_valid),
        .o_s1_sample (w_s1_sample),
        .o_s1_sum    (w_s1_sum)
    );

    smpc_eval #(
        .WINDOW (WINDOW)
    ) u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (w_s1_valid),
        .i_s1_sample (w_s1_sample),
        .i_s1_sum    (w_s1_sum),
        .o_s2_ready  (w_s2_ready),
        .i_cfg       (r_cfg),
        .o_out       (o_out)
    );

endmodule

@@ tb/tb_soil_moisture_pump_control_top.sv @@
// Self-checking testbench for soil_moisture_pump_control_top: random and directed sample words,
// random idling on both channels, and threshold/mode settings swept between phases.
// Depends on smpc_pkg, smpc_if and the block itself.
`timescale 1ns / 1ps

module tb_soil_moisture_pump_control_top;

    localparam int WINDOW        = smpc_pkg::WINDOW_DEFAULT;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 120;
    localparam int HOLD_CYCLES   = 150;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [smpc_pkg::SAMPLE_W-1:0] mean_level;
        logic                          anomaly;
        logic [smpc_pkg::PCT_W-1:0]    dry_percent;
        logic                          pump_on;
        smpc_pkg::t_lamp               lamp_select;
    } t_decision;

    class pump_decision_board;
        logic [smpc_pkg::SAMPLE_W-1:0] ring [WINDOW];
        int                            slot;
        bit                            primed;
        logic [smpc_pkg::SAMPLE_W-1:0] threshold;
        logic [1:0]                    mode;
        t_decision                     expected_decisions [$];
        int                            errors;
        int                            checked;
        int                            anomalies;

        function new();
            for (int i = 0; i < WINDOW; i++) ring[i] = '0;
            slot      = 0;
            primed    = 0;
            threshold = smpc_pkg::SAMPLE_W'(smpc_pkg::THRESHOLD_RESET);
            mode      = smpc_pkg::MODE_AUTO;
            errors    = 0;
            checked   = 0;
            anomalies = 0;
        endfunction

        function void set_reg(smpc_pkg::t_cfg_idx idx, logic [smpc_pkg::CFG_DATA_W-1:0] data);
            if (idx == smpc_pkg::CFG_IDX_THRESHOLD) threshold = data;
            else mode = data[1:0];
        endfunction

        function int pending();
            return expected_decisions.size();
        endfunction

        function void note_sample(logic [smpc_pkg::SAMPLE_W-1:0] s);
            int        sum;
            int        mean;
            int        diff;
            t_decision d;
            if (!primed) begin
                for (int i = 0; i < WINDOW; i++) ring[i] = s;
                slot   = 1 % WINDOW;
                primed = 1;
            end else begin
                ring[slot] = s;
                slot = (slot + 1) % WINDOW;
            end
            sum = 0;
            for (int i = 0; i < WINDOW; i++) sum += int'(ring[i]);
            mean = sum / WINDOW;
            diff = (int'(s) >= mean) ? int'(s) - mean : mean - int'(s);
            d.mean_level  = smpc_pkg::SAMPLE_W'(mean);
            d.anomaly     = diff > smpc_pkg::ANOMALY_LIMIT;
            d.dry_percent = smpc_pkg::PCT_W'((mean * smpc_pkg::PERCENT_SCALE)
                                             / smpc_pkg::FULL_SCALE);
            if (d.anomaly) begin
                d.pump_on = 0;
                d.lamp_select = smpc_pkg::LAMP_YELLOW;
            end else if (mode == smpc_pkg::MODE_FORCE_ON) begin
                d.pump_on = 1;
                d.lamp_select = smpc_pkg::LAMP_GREEN;
            end else if (mode == smpc_pkg::MODE_FORCE_OFF) begin
                d.pump_on = 0;
                d.lamp_select = smpc_pkg::LAMP_RED;
            end else if (mean > int'(threshold)) begin
                d.pump_on = 1;
                d.lamp_select = smpc_pkg::LAMP_GREEN;
            end else begin
                d.pump_on = 0;
                d.lamp_select = smpc_pkg::LAMP_RED;
            end
            expected_decisions.push_back(d);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %0d at %0t: %s got %0h expected %0h",
                     errors, $realtime, what, got, want);
        endtask

        task check_result(logic [smpc_pkg::SAMPLE_W-1:0] mean_level, logic anomaly,
                          logic [smpc_pkg::PCT_W-1:0] dry_percent, logic pump_on,
                          logic [1:0] lamp_select);
            t_decision w;
            if (expected_decisions.size() == 0) begin
                report("unexpected result word, mean_level", 32'(mean_level), 32'hffff_ffff);
            end else begin
                w = expected_decisions.pop_front();
                checked++;
                if (w.anomaly) anomalies++;
                if (mean_level !== w.mean_level)
                    report("mean_level", 32'(mean_level), 32'(w.mean_level));
                if (anomaly !== w.anomaly)
                    report("anomaly", 32'(anomaly), 32'(w.anomaly));
                if (dry_percent !== w.dry_percent)
                    report("dry_percent", 32'(dry_percent), 32'(w.dry_percent));
                if (pump_on !== w.pump_on)
                    report("pump_on", 32'(pump_on), 32'(w.pump_on));
                if (lamp_select !== w.lamp_select)
                    report("lamp_select", 32'(lamp_select), 32'(w.lamp_select));
            end
        endtask
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [smpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [smpc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    smpc_in_if  in_ch ();
    smpc_out_if out_ch ();

    pump_decision_board board;
    bit no_idle;
    int hold_req;
    int samples_sent;
    int cfg_writes;

    soil_moisture_pump_control_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("timeout waiting for result words");
        $display("[soil_moisture_pump_control_top] ERROR");
        $finish;
    end

    function automatic int clamp_level(int v);
        if (v < 0) return 0;
        if (v > smpc_pkg::FULL_SCALE) return smpc_pkg::FULL_SCALE;
        return v;
    endfunction

    function automatic int next_level(int level, int thr);
        int pick;
        int step;
        pick = int'($urandom_range(0, 99));
        if (pick < 15) return int'($urandom_range(0, smpc_pkg::FULL_SCALE));
        if (pick < 25) begin
            step = int'($urandom_range(301, 800));
            return clamp_level($urandom_range(0, 1) ? level + step : level - step);
        end
        if (pick < 40) return clamp_level(thr + int'($urandom_range(0, 10)) - 5);
        return clamp_level(level + int'($urandom_range(0, 80)) - 40);
    endfunction

    task automatic send_sample(int s);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 9));
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= smpc_pkg::SAMPLE_W'(s);
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_sample(smpc_pkg::SAMPLE_W'(s));
        samples_sent++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(smpc_pkg::t_cfg_idx idx, logic [smpc_pkg::CFG_DATA_W-1:0] data);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, data);
        cfg_writes++;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int n;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
            end else begin
                n = no_idle ? 0 : int'($urandom_range(0, 9));
            end
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            board.check_result(out_ch.mean_level, out_ch.anomaly, out_ch.dry_percent,
                               out_ch.pump_on, out_ch.lamp_select);
        end
    end

    initial begin
        int directed [] = '{100, 475, 100, 100, 100, 100, 476, 1023, 1023, 1023, 1023, 1023,
                            0, 0, 0, 0, 0, 500, 500, 500, 500, 500};
        int level;
        int thr;
        logic [1:0] mode;
        board        = new();
        no_idle      = 0;
        hold_req     = 0;
        samples_sent = 0;
        cfg_writes   = 0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.sample <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // prime the window, hit the anomaly boundary, the full-scale and zero ends
        foreach (directed[k]) send_sample(directed[k]);

        level = 500;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin thr = 0;    mode = smpc_pkg::MODE_AUTO;      end
                1: begin thr = 1023; mode = smpc_pkg::MODE_AUTO;      end
                2: begin thr = 1;    mode = smpc_pkg::MODE_FORCE_ON;  end
                3: begin thr = int'($urandom_range(0, 1023)); mode = smpc_pkg::MODE_FORCE_OFF; end
                4: begin thr = int'($urandom_range(0, 1023)); mode = MODE_UNUSED; end
                default: begin
                    thr  = int'($urandom_range(0, 1023));
                    mode = 2'($urandom_range(0, 3));
                end
            endcase
            write_reg(smpc_pkg::CFG_IDX_THRESHOLD, smpc_pkg::CFG_DATA_W'(thr));
            write_reg(smpc_pkg::CFG_IDX_MODE, {8'($urandom_range(0, 255)), mode});
            no_idle = (p == 2) || ($urandom_range(0, 3) == 0);
            if (p == 2) hold_req = HOLD_CYCLES;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                level = next_level(level, thr);
                send_sample(level);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d samples over %0d settings, %0d config writes",
                 samples_sent, PHASES + 1, cfg_writes);
        $display("checked %0d result words, %0d of them anomalies",
                 board.checked, board.anomalies);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("[soil_moisture_pump_control_top] OK");
        end else begin
            $display("[soil_moisture_pump_control_top] ERROR");
        end
        $finish;
    end

endmodule

@@ soil_moisture_pump_control_top.f @@
src/smpc_pkg.sv
src/smpc_if.sv
src/smpc_cell.sv
src/smpc_window.sv
src/smpc_eval.sv
src/soil_moisture_pump_control_top.sv
tb/tb_soil_moisture_pump_control_top.sv
